@@ hw/rtl/lss_pkg.sv @@
// Shared constants for the LIFO stack with search: operation and status codes, field widths.
package lss_pkg;

  localparam int DEPTH_DEFAULT = 128;

  localparam int WORD_W  = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int FOUND_W = 7;
  localparam int FILL_W  = 8;
  localparam int OUT_W   = 48;

  localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

endpackage

@@ hw/rtl/lifo_stack_with_search_unit.sv @@
// LIFO stack of 32-bit words with a linear bottom-up search, held in one synchronous memory.
// A push, an unused op or any error gives its result item straight from the accept; a pop
// first reads the memory in S_READ (registered memory read), and a search visits entries from
// the bottom in S_SCAN, up to the fill count. One item is at work at a time: no new item is
// taken until the last result has moved on to the output register. A result may wait at the output.
// Synchronous reset empties the stack at once; the memory needs no clearing pass.
module lifo_stack_with_search_unit #(
  parameter int DEPTH = lss_pkg::DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [lss_pkg::WORD_W-1:0]    s_tdata,  // value
  input  logic [lss_pkg::OP_W-1:0]      s_tuser,  // op
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lss_pkg::OUT_W-1:0]     m_tdata,  // popped_value, found_index, fill_count, pad
  output logic [lss_pkg::STAT_W-1:0]    m_tuser   // status
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PAD_W = lss_pkg::OUT_W - lss_pkg::WORD_W - lss_pkg::FOUND_W - lss_pkg::FILL_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_SCAN = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic [lss_pkg::WORD_W-1:0] mem [DEPTH];
  logic [lss_pkg::WORD_W-1:0] rd_data;
  logic [IW-1:0]              rd_addr;

  logic [CW-1:0]              count;
  logic [CW-1:0]              cnt_m1;
  logic [IW-1:0]              idx;
  logic [IW-1:0]              idx_p1;
  logic [lss_pkg::WORD_W-1:0] key;

  logic                        res_valid;
  logic [lss_pkg::STAT_W-1:0]  res_status;
  logic [lss_pkg::WORD_W-1:0]  res_popped;
  logic [lss_pkg::FOUND_W-1:0] res_found;
  logic [lss_pkg::FILL_W-1:0]  res_fill;

  logic                        accept;
  logic                        is_full;
  logic                        is_empty;
  logic                        push_ok;
  logic [IW+lss_pkg::FOUND_W-1:0] idx_wide;
  logic [CW+lss_pkg::FILL_W-1:0]  cnt_wide;
  logic [CW+lss_pkg::FILL_W-1:0]  cnt_m1_wide;
  logic [CW+lss_pkg::FILL_W-1:0]  cnt_p1_wide;
  logic                        drain;

  assign s_tready    = (state == S_IDLE) && !res_valid;
  assign accept      = s_tvalid && s_tready;
  assign is_full     = (count == CW'(DEPTH));
  assign is_empty    = (count == '0);
  assign push_ok     = accept && (s_tuser == lss_pkg::OP_PUSH) && !is_full;
  assign cnt_m1      = count - 1'b1;
  assign idx_p1      = idx + 1'b1;
  assign idx_wide    = {{lss_pkg::FOUND_W{1'b0}}, idx};
  assign cnt_wide    = {{lss_pkg::FILL_W{1'b0}}, count};
  assign cnt_m1_wide = {{lss_pkg::FILL_W{1'b0}}, cnt_m1};
  assign cnt_p1_wide = cnt_wide + 1'b1;
  assign drain       = res_valid && (!m_tvalid || m_tready);

  always_comb begin
    if (state == S_SCAN) begin
      rd_addr = idx_p1;
    end else if (s_tuser == lss_pkg::OP_POP) begin
      rd_addr = cnt_m1[IW-1:0];
    end else begin
      rd_addr = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[count[IW-1:0]] <= s_tdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && !is_empty) begin
          if (s_tuser == lss_pkg::OP_POP) begin
            state_next = S_READ;
          end else if (s_tuser == lss_pkg::OP_SEARCH) begin
            state_next = S_SCAN;
          end
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      S_SCAN: begin
        if ((rd_data == key) || (idx == cnt_m1[IW-1:0])) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (drain) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            key        <= s_tdata;
            idx        <= '0;
            res_popped <= '0;
            res_found  <= '0;
            res_status <= lss_pkg::ST_OK;
            res_fill   <= cnt_wide[lss_pkg::FILL_W-1:0];
            case (s_tuser)
              lss_pkg::OP_PUSH: begin
                res_valid <= 1'b1;
                if (is_full) begin
                  res_status <= lss_pkg::ST_OVERFLOW;
                end else begin
                  count    <= count + 1'b1;
                  res_fill <= cnt_p1_wide[lss_pkg::FILL_W-1:0];
                end
              end
              lss_pkg::OP_POP: begin
                if (is_empty) begin
                  res_valid  <= 1'b1;
                  res_status <= lss_pkg::ST_EMPTY;
                end else begin
                  count    <= cnt_m1;
                  res_fill <= cnt_m1_wide[lss_pkg::FILL_W-1:0];
                end
              end
              lss_pkg::OP_SEARCH: begin
                if (is_empty) begin
                  res_valid  <= 1'b1;
                  res_status <= lss_pkg::ST_EMPTY;
                end
              end
              default: begin
                res_valid <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          res_popped <= rd_data;
          res_valid  <= 1'b1;
        end
        S_SCAN: begin
          if (rd_data == key) begin
            res_found <= idx_wide[lss_pkg::FOUND_W-1:0];
            res_valid <= 1'b1;
          end else if (idx == cnt_m1[IW-1:0]) begin
            res_status <= lss_pkg::ST_NOTFOUND;
            res_valid  <= 1'b1;
          end else begin
            idx <= idx_p1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (drain) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      m_tdata <= {{PAD_W{1'b0}}, res_fill, res_found, res_popped};
      m_tuser <= res_status;
    end
  end

endmodule

@@ hw/rtl/lss_checker.sv @@
// Port-level checks for the LIFO stack with search, bound to the top level.
module lss_checker #(
  parameter int DEPTH = lss_pkg::DEPTH_DEFAULT
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [lss_pkg::WORD_W-1:0] s_tdata,
  input logic [lss_pkg::OP_W-1:0]   s_tuser,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [lss_pkg::OUT_W-1:0]  m_tdata,
  input logic [lss_pkg::STAT_W-1:0] m_tuser
);

  localparam logic [lss_pkg::FILL_W-1:0] FULL_FILL = lss_pkg::FILL_W'(DEPTH);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("Result item changed while stalled.");

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result item shown right after reset.");

  a_overflow_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == lss_pkg::ST_OVERFLOW) |-> m_tdata[46:39] == FULL_FILL)
    else $error("Overflow reported while the stack is not full.");

  a_empty_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == lss_pkg::ST_EMPTY) |->
      (m_tdata[46:39] == '0) && (m_tdata[38:0] == '0))
    else $error("Empty status with nonzero fields.");

  a_notfound_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == lss_pkg::ST_NOTFOUND) |->
      (m_tdata[38:0] == '0) && (m_tdata[46:39] != '0))
    else $error("Key-not-found status with bad fields.");

endmodule

bind lifo_stack_with_search_unit lss_checker #(.DEPTH(DEPTH)) u_lss_checker (.*);

@@ dv/tb.sv @@
// Self-checking testbench for the LIFO stack with search: random stream traffic and a predictor.
module tb;

  localparam int STACK_DEPTH = lss_pkg::DEPTH_DEFAULT;
  localparam logic [lss_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_OPS = 500;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 2 * STACK_DEPTH + 100;
  localparam int MODE_FILL = 0;
  localparam int MODE_DRAIN = 1;
  localparam int MODE_MIXED = 2;

  typedef struct {
    logic [lss_pkg::OP_W-1:0]   op;
    logic [lss_pkg::WORD_W-1:0] value;
  } stack_op_t;

  typedef struct {
    logic [lss_pkg::STAT_W-1:0]  status;
    logic [lss_pkg::WORD_W-1:0]  popped_value;
    logic [lss_pkg::FOUND_W-1:0] found_index;
    logic [lss_pkg::FILL_W-1:0]  fill_count;
  } stack_result_t;

  logic                       clk;
  logic                       rst;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [lss_pkg::WORD_W-1:0] s_tdata = '0;
  logic [lss_pkg::OP_W-1:0]   s_tuser = '0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [lss_pkg::OUT_W-1:0]  m_tdata;
  logic [lss_pkg::STAT_W-1:0] m_tuser;

  stack_op_t                  pending_ops[$];
  stack_result_t              expected_results[$];
  logic [lss_pkg::WORD_W-1:0] model_words[STACK_DEPTH];
  int                         model_fill;
  logic [lss_pkg::WORD_W-1:0] planned_words[$];
  bit                         failed;
  int                         cycle_count;
  bit                         op_taken;
  int                         send_gap;
  int                         stall_left;
  bit                         send_calm;
  bit                         recv_calm;

  lifo_stack_with_search_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int draw_gap(bit calm);
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [lss_pkg::WORD_W-1:0] draw_word();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) begin
      return $urandom_range(0, 7);
    end
    if (r == 3) begin
      case ($urandom_range(0, 3))
        0: return 32'h0000_0000;
        1: return 32'hFFFF_FFFF;
        2: return 32'h8000_0000;
        default: return 32'h7FFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  function automatic logic [lss_pkg::WORD_W-1:0] draw_key();
    if (planned_words.size() > 0 && $urandom_range(0, 9) < 6) begin
      return planned_words[$urandom_range(0, planned_words.size() - 1)];
    end
    return draw_word();
  endfunction

  task automatic queue_op(logic [lss_pkg::OP_W-1:0] op, logic [lss_pkg::WORD_W-1:0] value);
    stack_op_t item;
    item.op = op;
    item.value = value;
    pending_ops.push_back(item);
    if (op == lss_pkg::OP_PUSH && planned_words.size() < STACK_DEPTH) begin
      planned_words.push_back(value);
    end else if (op == lss_pkg::OP_POP && planned_words.size() > 0) begin
      void'(planned_words.pop_back());
    end
  endtask

  task automatic predict_stack_op(logic [lss_pkg::OP_W-1:0] op,
                                  logic [lss_pkg::WORD_W-1:0] value);
    stack_result_t res;
    int i;
    res.status = lss_pkg::ST_OK;
    res.popped_value = '0;
    res.found_index = '0;
    case (op)
      lss_pkg::OP_PUSH: begin
        if (model_fill >= STACK_DEPTH) begin
          res.status = lss_pkg::ST_OVERFLOW;
        end else begin
          model_words[model_fill] = value;
          model_fill++;
        end
      end
      lss_pkg::OP_POP: begin
        if (model_fill == 0) begin
          res.status = lss_pkg::ST_EMPTY;
        end else begin
          model_fill--;
          res.popped_value = model_words[model_fill];
        end
      end
      lss_pkg::OP_SEARCH: begin
        if (model_fill == 0) begin
          res.status = lss_pkg::ST_EMPTY;
        end else begin
          res.status = lss_pkg::ST_NOTFOUND;
          for (i = 0; i < model_fill; i++) begin
            if (model_words[i] == value) begin
              res.status = lss_pkg::ST_OK;
              res.found_index = i[lss_pkg::FOUND_W-1:0];
              break;
            end
          end
        end
      end
      default: ;
    endcase
    res.fill_count = model_fill[lss_pkg::FILL_W-1:0];
    expected_results.push_back(res);
  endtask

  task automatic check_field(string name, logic [lss_pkg::WORD_W-1:0] want,
                             logic [lss_pkg::WORD_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%h, got 0x%h", name, want, got);
      failed = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    stack_result_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      op_taken <= !rst && s_tvalid && s_tready;
      if (!rst && s_tvalid && s_tready) begin
        predict_stack_op(s_tuser, s_tdata);
      end
      if (!rst && m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d, data 0x%h", m_tuser, m_tdata);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          check_field("status", lss_pkg::WORD_W'(want.status),
                      lss_pkg::WORD_W'(m_tuser));
          check_field("popped_value", want.popped_value, m_tdata[31:0]);
          check_field("found_index", lss_pkg::WORD_W'(want.found_index),
                      lss_pkg::WORD_W'(m_tdata[38:32]));
          check_field("fill_count", lss_pkg::WORD_W'(want.fill_count),
                      lss_pkg::WORD_W'(m_tdata[46:39]));
        end
      end
    end
  end

  always @(negedge clk) begin
    stack_op_t next_op;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || op_taken) begin
      if ($urandom_range(0, 99) < 4) begin
        send_calm = !send_calm;
      end
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() > 0) begin
        next_op = pending_ops.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= next_op.value;
        s_tuser <= next_op.op;
        send_gap = draw_gap(send_calm);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 99) < 3) begin
        recv_calm = !recv_calm;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        stall_left = ($urandom_range(0, 3) == 0) ? draw_gap(recv_calm) : 0;
      end
    end
  end

  initial begin
    int mode;
    int seg_len;
    int seg_idx;
    int random_count;
    int r;
    int push_pct;
    int pop_pct;
    int search_pct;
    rst = 1'b1;

    // Errors on an empty stack and the unused op code first.
    queue_op(lss_pkg::OP_POP, 32'hFFFF_FFFF);
    queue_op(lss_pkg::OP_SEARCH, 32'h0000_0000);
    queue_op(OP_UNUSED, 32'h0000_0000);
    queue_op(lss_pkg::OP_PUSH, 32'h8000_0000);
    queue_op(lss_pkg::OP_PUSH, 32'h7FFF_FFFF);
    queue_op(lss_pkg::OP_PUSH, 32'h0000_0000);
    queue_op(lss_pkg::OP_PUSH, 32'hFFFF_FFFF);
    queue_op(lss_pkg::OP_PUSH, 32'h8000_0000);
    // A repeated key must report its lowest index.
    queue_op(lss_pkg::OP_SEARCH, 32'h8000_0000);
    queue_op(lss_pkg::OP_SEARCH, 32'hFFFF_FFFF);
    queue_op(lss_pkg::OP_SEARCH, 32'h0000_0001);
    queue_op(lss_pkg::OP_SEARCH, 32'h0000_0000);
    queue_op(OP_UNUSED, 32'hFFFF_FFFF);
    queue_op(lss_pkg::OP_POP, 32'h0000_0000);
    queue_op(lss_pkg::OP_POP, 32'h0000_0000);
    queue_op(lss_pkg::OP_SEARCH, 32'h7FFF_FFFF);
    queue_op(lss_pkg::OP_POP, 32'h0000_0000);
    queue_op(lss_pkg::OP_POP, 32'h0000_0000);
    queue_op(lss_pkg::OP_POP, 32'h0000_0000);
    queue_op(lss_pkg::OP_POP, 32'h0000_0000);
    queue_op(lss_pkg::OP_SEARCH, 32'h8000_0000);

    // The first two runs mostly push, then mostly pop, to drive the stack toward full and back toward empty.
    random_count = 0;
    seg_idx = 0;
    while (random_count < RANDOM_OPS) begin
      if (seg_idx == 0) begin
        mode = MODE_FILL;
        seg_len = 160;
      end else if (seg_idx == 1) begin
        mode = MODE_DRAIN;
        seg_len = 160;
      end else begin
        mode = $urandom_range(MODE_FILL, MODE_MIXED);
        seg_len = $urandom_range(20, 80);
      end
      case (mode)
        MODE_FILL: begin
          push_pct = 85;
          pop_pct = 0;
          search_pct = 15;
        end
        MODE_DRAIN: begin
          push_pct = 5;
          pop_pct = 80;
          search_pct = 15;
        end
        default: begin
          push_pct = 40;
          pop_pct = 35;
          search_pct = 22;
        end
      endcase
      repeat (seg_len) begin
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
          queue_op(lss_pkg::OP_PUSH, draw_word());
        end else if (r < push_pct + pop_pct) begin
          queue_op(lss_pkg::OP_POP, $urandom);
        end else if (r < push_pct + pop_pct + search_pct) begin
          queue_op(lss_pkg::OP_SEARCH, draw_key());
        end else begin
          queue_op(OP_UNUSED, $urandom);
        end
        random_count++;
      end
      seg_idx++;
    end

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (pending_ops.size() > 0 || s_tvalid || expected_results.size() > 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (!failed && expected_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
